/* rtl/msaa_pkg.sv */
package msaa_pkg;

  localparam int SAMPLE_COUNT = 4;
  localparam int CHAN_W       = 8;
  localparam int PIXEL_W      = 4 * CHAN_W;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [SAMPLE_COUNT-1:0] mask_t;

  typedef struct packed {
    pixel_t bg_colour;
    pixel_t a_colour;
    mask_t  a_mask;
    pixel_t b_colour;
    mask_t  b_mask;
  } in_t;

  typedef struct packed {
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    chan_t out_alpha;
  } out_t;

  // Rounded division by 255 for products of two 8-bit values and their sums
  // (at most 255 * 255), so the result always fits in eight bits.
  function automatic chan_t rnd255(input logic [15:0] x);
    logic [16:0] t;
    logic [16:0] s;
    t = {1'b0, x} + 17'd128;
    s = t + {8'd0, t[16:8]};
    return s[15:8];
  endfunction

endpackage

/* rtl/msaa_over.sv */
module msaa_over
  import msaa_pkg::*;
(
  input  logic       clk,
  input  logic [2:0] stage_en,
  input  logic       mask_bit,
  input  pixel_t     top,
  input  pixel_t     under,
  output pixel_t     result
);

  chan_t       ta;
  chan_t       ba;
  chan_t       inv;

  // First stage: all products that use the input alphas.
  logic [2:0][15:0] tt1;
  logic [2:0][15:0] cb1;
  logic [15:0]      ai1;
  chan_t            ta1;
  chan_t            inv1;
  logic             cover1;
  pixel_t           px1;

  // Second stage: the premultiplied bottom scaled by the inverse top alpha.
  logic [2:0][15:0] tt2;
  logic [2:0][15:0] m2;
  chan_t            alpha2;
  logic             cover2;
  pixel_t           px2;

  logic [8:0]       alpha_sum;

  assign ta  = top[31:24];
  assign ba  = under[31:24];
  assign inv = 8'd255 - ta;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      for (int c = 0; c < 3; c++) begin
        tt1[c] <= top[8*c +: 8] * ta;
        cb1[c] <= under[8*c +: 8] * ba;
      end
      ai1    <= ba * inv;
      ta1    <= ta;
      inv1   <= inv;
      cover1 <= mask_bit;
      px1    <= under;
    end
  end

  assign alpha_sum = {1'b0, ta1} + {1'b0, rnd255(ai1)};

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      for (int c = 0; c < 3; c++) begin
        m2[c]  <= rnd255(cb1[c]) * inv1;
        tt2[c] <= tt1[c];
      end
      alpha2 <= alpha_sum[7:0];
      cover2 <= cover1;
      px2    <= px1;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      if (cover2) begin
        for (int c = 0; c < 3; c++) begin
          result[8*c +: 8] <= rnd255(tt2[c] + m2[c]);
        end
        result[31:24] <= alpha2;
      end else begin
        result <= px2;
      end
    end
  end

endmodule

/* rtl/msaa_merge.sv */
module msaa_merge
  import msaa_pkg::*;
(
  input  logic                          clk,
  input  logic                          en,
  input  logic [SAMPLE_COUNT-1:0][31:0] samples,
  output out_t                          result
);

  logic [3:0][9:0] sum;
  logic [3:0][9:0] avg;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c] = 10'd0;
      for (int s = 0; s < SAMPLE_COUNT; s++) begin
        sum[c] = sum[c] + {2'b00, samples[s][8*c +: 8]};
      end
      avg[c] = (sum[c] + 10'd2) >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.out_red   <= avg[0][7:0];
      result.out_green <= avg[1][7:0];
      result.out_blue  <= avg[2][7:0];
      result.out_alpha <= avg[3][7:0];
    end
  end

endmodule

/* rtl/msaa_two_layer_blend_resolve_top.sv */
// Seven register stages. Throughput: one pixel per cycle while no result waits on stall;
// each of the four sample lanes runs two three-stage blend units back to back, and a
// merge stage averages the lanes.
// Stages with no transaction in them keep accepting while a result waits on stall.
// Reset clears all valid bits; the data registers are not reset.
module msaa_two_layer_blend_resolve_top
  import msaa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic pixel_valid,
  output logic pixel_stall,
  input  in_t  pixel,
  output logic result_valid,
  input  logic result_stall,
  output out_t result
);

  localparam int PIPE_DEPTH = 7;

  logic [PIPE_DEPTH-1:0] v;
  logic [PIPE_DEPTH-1:0] en;

  pixel_t [2:0] b_colour_d;
  mask_t  [2:0] b_mask_d;

  logic [SAMPLE_COUNT-1:0][31:0] lower;
  logic [SAMPLE_COUNT-1:0][31:0] upper;

  // A stage loads when it is empty or when the stage after it moves.
  always_comb begin
    en[PIPE_DEPTH-1] = !v[PIPE_DEPTH-1] || !result_stall;
    for (int k = PIPE_DEPTH-2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign pixel_stall  = !en[0];
  assign result_valid = v[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= pixel_valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // The upper fragment waits here while the lower one is blended.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      b_colour_d[0] <= pixel.b_colour;
      b_mask_d[0]   <= pixel.b_mask;
    end
    for (int k = 1; k < 3; k++) begin
      if (en[k]) begin
        b_colour_d[k] <= b_colour_d[k-1];
        b_mask_d[k]   <= b_mask_d[k-1];
      end
    end
  end

  for (genvar s = 0; s < SAMPLE_COUNT; s++) begin : g_lane
    msaa_over u_over_a (
      .clk      (clk),
      .stage_en (en[2:0]),
      .mask_bit (pixel.a_mask[s]),
      .top      (pixel.a_colour),
      .under    (pixel.bg_colour),
      .result   (lower[s])
    );

    msaa_over u_over_b (
      .clk      (clk),
      .stage_en (en[5:3]),
      .mask_bit (b_mask_d[2][s]),
      .top      (b_colour_d[2]),
      .under    (lower[s]),
      .result   (upper[s])
    );
  end

  msaa_merge u_merge (
    .clk     (clk),
    .en      (en[PIPE_DEPTH-1]),
    .samples (upper),
    .result  (result)
  );

endmodule

/* rtl/msaa_chk.sv */
module msaa_chk
  import msaa_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic pixel_valid,
  input logic pixel_stall,
  input logic result_valid,
  input logic result_stall,
  input out_t result
);

  // A stalled result transaction stays offered with the same payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // When the output register is free to move, every stage can move too.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!result_valid || !result_stall) |-> !pixel_stall)
    else $error("input stalled although the output moves");

  // Input stall can only come from a result held at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> result_valid && result_stall)
    else $error("input stalled without a held result");

endmodule

bind msaa_two_layer_blend_resolve_top msaa_chk u_msaa_chk (.*);
